// File: rtl/assert_macros.svh
// assertion macros for the rtl files
// depends on nothing; pulled in by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

// File: rtl/acceu_pkg.sv
// types and constants of the accumulator cpu execute unit
// no dependencies; used by accumulator_cpu_execute_unit
package acceu_pkg;

    // operation codes
    localparam logic [5:0] OP_ADC = 6'd0;
    localparam logic [5:0] OP_SBC = 6'd1;
    localparam logic [5:0] OP_AND = 6'd2;
    localparam logic [5:0] OP_ORA = 6'd3;
    localparam logic [5:0] OP_EOR = 6'd4;
    localparam logic [5:0] OP_BIT = 6'd5;
    localparam logic [5:0] OP_CMP = 6'd6;
    localparam logic [5:0] OP_CPX = 6'd7;
    localparam logic [5:0] OP_CPY = 6'd8;
    localparam logic [5:0] OP_LDA = 6'd9;
    localparam logic [5:0] OP_LDX = 6'd10;
    localparam logic [5:0] OP_LDY = 6'd11;
    localparam logic [5:0] OP_STA = 6'd12;
    localparam logic [5:0] OP_STX = 6'd13;
    localparam logic [5:0] OP_STY = 6'd14;
    localparam logic [5:0] OP_INC = 6'd15;
    localparam logic [5:0] OP_DEC = 6'd16;
    localparam logic [5:0] OP_INX = 6'd17;
    localparam logic [5:0] OP_INY = 6'd18;
    localparam logic [5:0] OP_DEX = 6'd19;
    localparam logic [5:0] OP_DEY = 6'd20;
    localparam logic [5:0] OP_ASL = 6'd21;
    localparam logic [5:0] OP_LSR = 6'd22;
    localparam logic [5:0] OP_ROL = 6'd23;
    localparam logic [5:0] OP_ROR = 6'd24;
    localparam logic [5:0] OP_TAX = 6'd25;
    localparam logic [5:0] OP_TAY = 6'd26;
    localparam logic [5:0] OP_TXA = 6'd27;
    localparam logic [5:0] OP_TYA = 6'd28;
    localparam logic [5:0] OP_TSX = 6'd29;
    localparam logic [5:0] OP_TXS = 6'd30;
    localparam logic [5:0] OP_CLC = 6'd31;
    localparam logic [5:0] OP_SEC = 6'd32;
    localparam logic [5:0] OP_CLD = 6'd33;
    localparam logic [5:0] OP_SED = 6'd34;
    localparam logic [5:0] OP_CLI = 6'd35;
    localparam logic [5:0] OP_SEI = 6'd36;
    localparam logic [5:0] OP_CLV = 6'd37;
    localparam logic [5:0] OP_BCC = 6'd38;
    localparam logic [5:0] OP_BCS = 6'd39;
    localparam logic [5:0] OP_BEQ = 6'd40;
    localparam logic [5:0] OP_BNE = 6'd41;
    localparam logic [5:0] OP_BMI = 6'd42;
    localparam logic [5:0] OP_BPL = 6'd43;
    localparam logic [5:0] OP_BVC = 6'd44;
    localparam logic [5:0] OP_BVS = 6'd45;
    localparam logic [5:0] OP_NOP = 6'd46;

    // decimal adjust steps
    localparam logic [9:0] BCD_LO_ADJ = 10'h006;
    localparam logic [9:0] BCD_HI_ADJ = 10'h060;
    localparam logic [3:0] BCD_MAX_DIGIT = 4'd9;

    localparam logic [7:0] SP_RESET = 8'hFF;
    localparam logic [1:0] EXTRA_NONE = 2'd0;
    localparam logic [1:0] EXTRA_SAME_PAGE = 2'd1;
    localparam logic [1:0] EXTRA_TWO = 2'd2;

    // input word, last field in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [15:0] next_pc;
        logic [7:0]  operand;
        logic [5:0]  op;
    } t_item;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [3:0]  pad;
        logic [1:0]  extra_cycles;
        logic        branch_taken;
        logic [15:0] new_pc;
        logic [7:0]  status_out;
        logic [7:0]  sp_out;
        logic [7:0]  y_out;
        logic [7:0]  x_out;
        logic [7:0]  acc_out;
        logic        mem_write;
        logic [7:0]  mem_data;
    } t_result;

endpackage

// File: rtl/accumulator_cpu_execute_unit.sv
// Execute stage of an 8-bit accumulator cpu: alu, flags, register file, branches.
// An input word is held in the input register, then its result in the result register.
// Throughput: one word per cycle; the input register, the single-pass alu and the
// result register form a two-deep pipe, so input stalls only when both are held.
// Reset (synchronous, active low): A, X, Y and flags cleared, SP set to 0xFF, pipe empty.
// Depends on acceu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module accumulator_cpu_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // op[5:0], operand[13:6], next_pc[29:14], zeros
    input  logic [0:0]  s_axis_tuser,   // on_accumulator[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // mem_data[7:0], mem_write[8], acc_out[16:9],
                                        // x_out[24:17], y_out[32:25], sp_out[40:33],
                                        // status_out[48:41], new_pc[64:49],
                                        // branch_taken[65], extra_cycles[67:66], zeros
);

    acceu_pkg::t_item   r_in;
    logic               r_in_acc;
    logic               r_in_valid;
    acceu_pkg::t_result r_out;
    acceu_pkg::t_result n_out;
    logic               r_out_valid;

    logic [7:0] r_a, r_x, r_y, r_sp;
    logic [7:0] n_a, n_x, n_y, n_sp;
    logic       r_c, r_z, r_i, r_d, r_v, r_n;
    logic       n_c, n_z, n_i, n_d, n_v, n_n;

    logic w_out_free;
    logic w_adv;
    logic w_take;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_adv         = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // decimal-capable add, 10 bits so carry survives the adjust
    logic [9:0] w_add0, w_add1, w_add2;
    // subtract kept as 10-bit two's complement; bit 9 set means it went below zero
    logic [9:0] w_sub0, w_sub1, w_sub2;
    logic [7:0] w_m;

    assign w_m = r_in.operand;

    always_comb begin
        w_add0 = {2'b00, r_a} + {2'b00, w_m} + {9'd0, r_c};
        w_add1 = w_add0;
        if (r_d && (w_add0[3:0] > acceu_pkg::BCD_MAX_DIGIT)) begin
            w_add1 = w_add0 + acceu_pkg::BCD_LO_ADJ;
        end
        w_add2 = w_add1;
        if (r_d && (w_add1[7:4] > acceu_pkg::BCD_MAX_DIGIT)) begin
            w_add2 = w_add1 + acceu_pkg::BCD_HI_ADJ;
        end
    end

    always_comb begin
        w_sub0 = {2'b00, r_a} - {2'b00, w_m} - {9'd0, !r_c};
        w_sub1 = w_sub0;
        if (r_d && (w_sub0[3:0] > acceu_pkg::BCD_MAX_DIGIT)) begin
            w_sub1 = w_sub0 - acceu_pkg::BCD_LO_ADJ;
        end
        w_sub2 = w_sub1;
        if (r_d && (w_sub1[7:4] > acceu_pkg::BCD_MAX_DIGIT)) begin
            w_sub2 = w_sub1 - acceu_pkg::BCD_HI_ADJ;
        end
    end

    logic [15:0] w_br_pc;
    logic        w_cond;

    assign w_br_pc = r_in.next_pc + {{8{w_m[7]}}, w_m};

    always_comb begin
        case (r_in.op)
            acceu_pkg::OP_BCC: w_cond = !r_c;
            acceu_pkg::OP_BCS: w_cond = r_c;
            acceu_pkg::OP_BEQ: w_cond = r_z;
            acceu_pkg::OP_BNE: w_cond = !r_z;
            acceu_pkg::OP_BMI: w_cond = r_n;
            acceu_pkg::OP_BPL: w_cond = !r_n;
            acceu_pkg::OP_BVC: w_cond = !r_v;
            acceu_pkg::OP_BVS: w_cond = r_v;
            default:           w_cond = 1'b0;
        endcase
    end

    // shift and rotate source and result
    logic [7:0] w_sh_src;
    logic [7:0] w_sh_val;
    logic       w_sh_c;

    assign w_sh_src = r_in_acc ? r_a : w_m;

    always_comb begin
        case (r_in.op)
            acceu_pkg::OP_ASL: begin
                w_sh_val = {w_sh_src[6:0], 1'b0};
                w_sh_c   = w_sh_src[7];
            end
            acceu_pkg::OP_ROL: begin
                w_sh_val = {w_sh_src[6:0], r_c};
                w_sh_c   = w_sh_src[7];
            end
            acceu_pkg::OP_ROR: begin
                w_sh_val = {r_c, w_sh_src[7:1]};
                w_sh_c   = w_sh_src[0];
            end
            default: begin
                w_sh_val = {1'b0, w_sh_src[7:1]};
                w_sh_c   = w_sh_src[0];
            end
        endcase
    end

    // main decode
    logic [7:0] w_nz;
    logic       w_nz_en;
    logic [7:0] w_cmp_reg;
    logic [8:0] w_cmp_diff;

    always_comb begin
        case (r_in.op)
            acceu_pkg::OP_CPX: w_cmp_reg = r_x;
            acceu_pkg::OP_CPY: w_cmp_reg = r_y;
            default:           w_cmp_reg = r_a;
        endcase
    end

    assign w_cmp_diff = {1'b0, w_cmp_reg} - {1'b0, w_m};

    always_comb begin
        n_a  = r_a;
        n_x  = r_x;
        n_y  = r_y;
        n_sp = r_sp;
        n_c  = r_c;
        n_z  = r_z;
        n_i  = r_i;
        n_d  = r_d;
        n_v  = r_v;
        n_n  = r_n;
        w_nz    = 8'd0;
        w_nz_en = 1'b0;
        n_out.pad          = '0;
        n_out.mem_data     = 8'd0;
        n_out.mem_write    = 1'b0;
        n_out.new_pc       = r_in.next_pc;
        n_out.branch_taken = 1'b0;
        n_out.extra_cycles = acceu_pkg::EXTRA_NONE;

        unique case (r_in.op) inside
            acceu_pkg::OP_ADC: begin
                n_a     = w_add2[7:0];
                w_nz    = w_add2[7:0];
                w_nz_en = 1'b1;
                n_c     = |w_add2[9:8];
                n_v     = (r_a[7] ^ w_add2[7]) & (w_m[7] ^ w_add2[7]);
            end
            acceu_pkg::OP_SBC: begin
                n_a     = w_sub2[7:0];
                w_nz    = w_sub2[7:0];
                w_nz_en = 1'b1;
                n_c     = !w_sub2[9];
                n_v     = (r_a[7] ^ w_m[7]) & (r_a[7] ^ w_sub2[7]);
            end
            acceu_pkg::OP_AND: begin
                n_a = r_a & w_m; w_nz = r_a & w_m; w_nz_en = 1'b1;
            end
            acceu_pkg::OP_ORA: begin
                n_a = r_a | w_m; w_nz = r_a | w_m; w_nz_en = 1'b1;
            end
            acceu_pkg::OP_EOR: begin
                n_a = r_a ^ w_m; w_nz = r_a ^ w_m; w_nz_en = 1'b1;
            end
            acceu_pkg::OP_BIT: begin
                n_z = ((r_a & w_m) == 8'd0);
                n_v = w_m[6];
                n_n = w_m[7];
            end
            acceu_pkg::OP_CMP, acceu_pkg::OP_CPX, acceu_pkg::OP_CPY: begin
                n_c = !w_cmp_diff[8];
                n_z = (w_cmp_diff[7:0] == 8'd0);
                n_n = w_cmp_diff[7];
            end
            acceu_pkg::OP_LDA: begin
                n_a = w_m; w_nz = w_m; w_nz_en = 1'b1;
            end
            acceu_pkg::OP_LDX: begin
                n_x = w_m; w_nz = w_m; w_nz_en = 1'b1;
            end
            acceu_pkg::OP_LDY: begin
                n_y = w_m; w_nz = w_m; w_nz_en = 1'b1;
            end
            acceu_pkg::OP_STA: begin
                n_out.mem_data = r_a; n_out.mem_write = 1'b1;
            end
            acceu_pkg::OP_STX: begin
                n_out.mem_data = r_x; n_out.mem_write = 1'b1;
            end
            acceu_pkg::OP_STY: begin
                n_out.mem_data = r_y; n_out.mem_write = 1'b1;
            end
            acceu_pkg::OP_INC: begin
                w_nz               = w_m + 8'd1;
                w_nz_en            = 1'b1;
                n_out.mem_data     = w_m + 8'd1;
                n_out.mem_write    = 1'b1;
                n_out.extra_cycles = acceu_pkg::EXTRA_TWO;
            end
            acceu_pkg::OP_DEC: begin
                w_nz               = w_m - 8'd1;
                w_nz_en            = 1'b1;
                n_out.mem_data     = w_m - 8'd1;
                n_out.mem_write    = 1'b1;
                n_out.extra_cycles = acceu_pkg::EXTRA_TWO;
            end
            acceu_pkg::OP_INX: begin
                n_x = r_x + 8'd1; w_nz = r_x + 8'd1; w_nz_en = 1'b1;
            end
            acceu_pkg::OP_INY: begin
                n_y = r_y + 8'd1; w_nz = r_y + 8'd1; w_nz_en = 1'b1;
            end
            acceu_pkg::OP_DEX: begin
                n_x = r_x - 8'd1; w_nz = r_x - 8'd1; w_nz_en = 1'b1;
            end
            acceu_pkg::OP_DEY: begin
                n_y = r_y - 8'd1; w_nz = r_y - 8'd1; w_nz_en = 1'b1;
            end
            acceu_pkg::OP_ASL, acceu_pkg::OP_LSR, acceu_pkg::OP_ROL, acceu_pkg::OP_ROR: begin
                n_c     = w_sh_c;
                w_nz    = w_sh_val;
                w_nz_en = 1'b1;
                if (r_in_acc) begin
                    n_a = w_sh_val;
                end else begin
                    n_out.mem_data     = w_sh_val;
                    n_out.mem_write    = 1'b1;
                    n_out.extra_cycles = acceu_pkg::EXTRA_TWO;
                end
            end
            acceu_pkg::OP_TAX: begin
                n_x = r_a; w_nz = r_a; w_nz_en = 1'b1;
            end
            acceu_pkg::OP_TAY: begin
                n_y = r_a; w_nz = r_a; w_nz_en = 1'b1;
            end
            acceu_pkg::OP_TXA: begin
                n_a = r_x; w_nz = r_x; w_nz_en = 1'b1;
            end
            acceu_pkg::OP_TYA: begin
                n_a = r_y; w_nz = r_y; w_nz_en = 1'b1;
            end
            acceu_pkg::OP_TSX: begin
                n_x = r_sp; w_nz = r_sp; w_nz_en = 1'b1;
            end
            acceu_pkg::OP_TXS: n_sp = r_x;
            acceu_pkg::OP_CLC: n_c = 1'b0;
            acceu_pkg::OP_SEC: n_c = 1'b1;
            acceu_pkg::OP_CLD: n_d = 1'b0;
            acceu_pkg::OP_SED: n_d = 1'b1;
            acceu_pkg::OP_CLI: n_i = 1'b0;
            acceu_pkg::OP_SEI: n_i = 1'b1;
            acceu_pkg::OP_CLV: n_v = 1'b0;
            acceu_pkg::OP_BCC, acceu_pkg::OP_BCS, acceu_pkg::OP_BEQ, acceu_pkg::OP_BNE,
            acceu_pkg::OP_BMI, acceu_pkg::OP_BPL, acceu_pkg::OP_BVC, acceu_pkg::OP_BVS: begin
                if (w_cond) begin
                    n_out.new_pc       = w_br_pc;
                    n_out.branch_taken = 1'b1;
                    n_out.extra_cycles = (w_br_pc[15:8] == r_in.next_pc[15:8])
                                         ? acceu_pkg::EXTRA_SAME_PAGE
                                         : acceu_pkg::EXTRA_TWO;
                end
            end
            // nop and unused codes leave everything alone
            default: begin
            end
        endcase

        if (w_nz_en) begin
            n_z = (w_nz == 8'd0);
            n_n = w_nz[7];
        end

        n_out.acc_out    = n_a;
        n_out.x_out      = n_x;
        n_out.y_out      = n_y;
        n_out.sp_out     = n_sp;
        n_out.status_out = {n_n, n_v, 1'b1, 1'b0, n_d, n_i, n_z, n_c};
    end

    // pipe control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_a  <= 8'd0;
            r_x  <= 8'd0;
            r_y  <= 8'd0;
            r_sp <= acceu_pkg::SP_RESET;
            r_c  <= 1'b0;
            r_z  <= 1'b0;
            r_i  <= 1'b0;
            r_d  <= 1'b0;
            r_v  <= 1'b0;
            r_n  <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv) begin
                r_a  <= n_a;
                r_x  <= n_x;
                r_y  <= n_y;
                r_sp <= n_sp;
                r_c  <= n_c;
                r_z  <= n_z;
                r_i  <= n_i;
                r_d  <= n_d;
                r_v  <= n_v;
                r_n  <= n_n;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in     <= s_axis_tdata;
            r_in_acc <= s_axis_tuser[0];
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    `ASSERT_CLK(a_status_fixed_bits, i_clk, i_rst_n,
        r_out_valid |-> (r_out.status_out[5] && !r_out.status_out[4]),
        "status bits 5 and 4 wrong")
    `ASSERT_CLK(a_no_write_no_data, i_clk, i_rst_n,
        (r_out_valid && !r_out.mem_write) |-> (r_out.mem_data == 8'd0),
        "mem_data set without mem_write")
    `ASSERT_NEVER(a_branch_no_write, i_clk, i_rst_n,
        r_out_valid && r_out.branch_taken && r_out.mem_write,
        "taken branch also writes memory")
    `ASSERT_CLK(a_sp_only_txs, i_clk, i_rst_n,
        (r_sp != $past(r_sp)) |-> $past(w_adv && (r_in.op == acceu_pkg::OP_TXS)),
        "stack pointer changed outside txs")

endmodule

// File: tb/accumulator_cpu_execute_unit_test.sv
// self-checking testbench for accumulator_cpu_execute_unit: directed table, then random words
// predicts each result word from its own register and flag model, or takes it from the table row; needs acceu_pkg
module accumulator_cpu_execute_unit_test;

    localparam logic [5:0] OP_UNDEF_TOP = 6'd63;
    localparam int N_RANDOM    = 2000;
    localparam int PAUSE_AT    = 1000;
    localparam int HOLD_AT     = 1750;
    localparam int HOLD_CYCLES = 60;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        acceu_pkg::t_item   word;
        bit                 on_acc;
        bit                 typed;
        acceu_pkg::t_result want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;

    accumulator_cpu_execute_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // cpu state as the block should hold it
    logic [7:0] acc_q, x_q, y_q, sp_q;
    bit         fc, fz, fi, fd, fv, fn;

    acceu_pkg::t_result expected_words[$];
    int      err_count = 0;
    int      words_sent;
    int      results_seen = 0;
    int      decimal_ops;
    int      taken_branches;
    int      rmw_ops;
    int      input_stalls = 0;
    int      idle_run = 0;
    int      send_idle_pct;
    int      recv_idle_pct = 56;
    bit      hold_req;
    bit      hold_started = 1'b0;
    int      hold_left = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic set_nz(input logic [7:0] v);
        fz = (v == 8'h00);
        fn = v[7];
    endtask

    task automatic compare_reg(input logic [7:0] r, input logic [7:0] m);
        logic [7:0] d;
        d = r - m;
        fc = (r >= m);
        fz = (r == m);
        fn = d[7];
    endtask

    // executes one word on the model state and builds the result word it should give
    task automatic execute_op(input acceu_pkg::t_item w, input bit ua,
                              output acceu_pkg::t_result r);
        logic [7:0]  a, m, s, v, ovf;
        logic [9:0]  sum;
        logic [15:0] diff, off;
        bit          cond, cin;
        a = acc_q;
        m = w.operand;
        cond = 1'b0;
        r = '0;
        r.new_pc = w.next_pc;
        case (w.op)
            acceu_pkg::OP_ADC: begin
                sum = {2'b00, a} + {2'b00, m} + {9'd0, fc};
                if (fd) begin
                    if (sum[3:0] > 4'd9) sum = sum + 10'h006;
                    if (sum[7:4] > 4'd9) sum = sum + 10'h060;
                end
                acc_q = sum[7:0];
                set_nz(acc_q);
                fc = (sum > 10'h0FF);
                ovf = (a ^ acc_q) & (m ^ acc_q);
                fv = ovf[7];
            end
            acceu_pkg::OP_SBC: begin
                diff = {8'h00, a} - {8'h00, m} - {15'd0, ~fc};
                if (fd) begin
                    if (diff[3:0] > 4'd9) diff = diff - 16'h0006;
                    if (diff[7:4] > 4'd9) diff = diff - 16'h0060;
                end
                acc_q = diff[7:0];
                set_nz(acc_q);
                fc = (diff <= 16'h00FF);
                ovf = (a ^ m) & (a ^ acc_q);
                fv = ovf[7];
            end
            acceu_pkg::OP_AND: begin acc_q = a & m; set_nz(acc_q); end
            acceu_pkg::OP_ORA: begin acc_q = a | m; set_nz(acc_q); end
            acceu_pkg::OP_EOR: begin acc_q = a ^ m; set_nz(acc_q); end
            acceu_pkg::OP_BIT: begin
                fz = ((a & m) == 8'h00);
                fv = m[6];
                fn = m[7];
            end
            acceu_pkg::OP_CMP: compare_reg(a, m);
            acceu_pkg::OP_CPX: compare_reg(x_q, m);
            acceu_pkg::OP_CPY: compare_reg(y_q, m);
            acceu_pkg::OP_LDA: begin acc_q = m; set_nz(m); end
            acceu_pkg::OP_LDX: begin x_q = m; set_nz(m); end
            acceu_pkg::OP_LDY: begin y_q = m; set_nz(m); end
            acceu_pkg::OP_STA: begin r.mem_data = a; r.mem_write = 1'b1; end
            acceu_pkg::OP_STX: begin r.mem_data = x_q; r.mem_write = 1'b1; end
            acceu_pkg::OP_STY: begin r.mem_data = y_q; r.mem_write = 1'b1; end
            acceu_pkg::OP_INC, acceu_pkg::OP_DEC: begin
                v = (w.op == acceu_pkg::OP_INC) ? m + 8'd1 : m - 8'd1;
                set_nz(v);
                r.mem_data = v;
                r.mem_write = 1'b1;
                r.extra_cycles = acceu_pkg::EXTRA_TWO;
            end
            acceu_pkg::OP_INX: begin x_q = x_q + 8'd1; set_nz(x_q); end
            acceu_pkg::OP_INY: begin y_q = y_q + 8'd1; set_nz(y_q); end
            acceu_pkg::OP_DEX: begin x_q = x_q - 8'd1; set_nz(x_q); end
            acceu_pkg::OP_DEY: begin y_q = y_q - 8'd1; set_nz(y_q); end
            acceu_pkg::OP_ASL, acceu_pkg::OP_LSR, acceu_pkg::OP_ROL, acceu_pkg::OP_ROR: begin
                s = ua ? a : m;
                cin = fc;
                if (w.op == acceu_pkg::OP_ASL) begin
                    fc = s[7];
                    v = {s[6:0], 1'b0};
                end else if (w.op == acceu_pkg::OP_LSR) begin
                    fc = s[0];
                    v = {1'b0, s[7:1]};
                end else if (w.op == acceu_pkg::OP_ROL) begin
                    fc = s[7];
                    v = {s[6:0], cin};
                end else begin
                    fc = s[0];
                    v = {cin, s[7:1]};
                end
                set_nz(v);
                if (ua) begin
                    acc_q = v;
                end else begin
                    r.mem_data = v;
                    r.mem_write = 1'b1;
                    r.extra_cycles = acceu_pkg::EXTRA_TWO;
                end
            end
            acceu_pkg::OP_TAX: begin x_q = a; set_nz(a); end
            acceu_pkg::OP_TAY: begin y_q = a; set_nz(a); end
            acceu_pkg::OP_TXA: begin acc_q = x_q; set_nz(x_q); end
            acceu_pkg::OP_TYA: begin acc_q = y_q; set_nz(y_q); end
            acceu_pkg::OP_TSX: begin x_q = sp_q; set_nz(sp_q); end
            acceu_pkg::OP_TXS: sp_q = x_q;
            acceu_pkg::OP_CLC: fc = 1'b0;
            acceu_pkg::OP_SEC: fc = 1'b1;
            acceu_pkg::OP_CLD: fd = 1'b0;
            acceu_pkg::OP_SED: fd = 1'b1;
            acceu_pkg::OP_CLI: fi = 1'b0;
            acceu_pkg::OP_SEI: fi = 1'b1;
            acceu_pkg::OP_CLV: fv = 1'b0;
            acceu_pkg::OP_BCC: cond = !fc;
            acceu_pkg::OP_BCS: cond = fc;
            acceu_pkg::OP_BEQ: cond = fz;
            acceu_pkg::OP_BNE: cond = !fz;
            acceu_pkg::OP_BMI: cond = fn;
            acceu_pkg::OP_BPL: cond = !fn;
            acceu_pkg::OP_BVC: cond = !fv;
            acceu_pkg::OP_BVS: cond = fv;
            default: ;
        endcase
        if (cond) begin
            off = {{8{m[7]}}, m};
            r.new_pc = w.next_pc + off;
            r.branch_taken = 1'b1;
            r.extra_cycles = (r.new_pc[15:8] == w.next_pc[15:8]) ? acceu_pkg::EXTRA_SAME_PAGE
                                                                 : acceu_pkg::EXTRA_TWO;
        end
        r.acc_out = acc_q;
        r.x_out = x_q;
        r.y_out = y_q;
        r.sp_out = sp_q;
        r.status_out = {fn, fv, 1'b1, 1'b0, fd, fi, fz, fc};
    endtask

    function automatic t_stim_row plain_row(input logic [5:0] op, input logic [7:0] opnd,
                                            input bit ua, input logic [15:0] pc);
        t_stim_row row;
        row.word = '0;
        row.word.op = op;
        row.word.operand = opnd;
        row.word.next_pc = pc;
        row.on_acc = ua;
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    // rows whose result is plain from the reset state: x, y and sp untouched, no branch
    function automatic t_stim_row typed_row(input logic [5:0] op, input logic [7:0] opnd,
                                            input bit ua, input logic [15:0] pc,
                                            input logic [7:0] acc, input logic [7:0] st);
        t_stim_row row;
        row = plain_row(op, opnd, ua, pc);
        row.typed = 1'b1;
        row.want.acc_out = acc;
        row.want.sp_out = acceu_pkg::SP_RESET;
        row.want.status_out = st;
        row.want.new_pc = pc;
        row.want.extra_cycles = acceu_pkg::EXTRA_NONE;
        return row;
    endfunction

    // offers one word, then runs the model once it is taken; called at a falling edge
    task automatic send_word(input acceu_pkg::t_item w, input bit ua, input bit typed,
                             input acceu_pkg::t_result want);
        acceu_pkg::t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = w;
        s_axis_tuser = ua;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if ((w.op == acceu_pkg::OP_ADC || w.op == acceu_pkg::OP_SBC) && fd) decimal_ops++;
        execute_op(w, ua, predicted);
        if (predicted.branch_taken) taken_branches++;
        if (predicted.extra_cycles == acceu_pkg::EXTRA_TWO && !predicted.branch_taken)
            rmw_ops++;
        expected_words.push_back(typed ? want : predicted);
        words_sent++;
        if (words_sent == HOLD_AT) hold_req = 1'b1;
        if (words_sent < (N_RANDOM + 30) / 3) begin
            send_idle_pct = 26;
            recv_idle_pct = 56;
        end else if (words_sent < 2 * (N_RANDOM + 30) / 3) begin
            send_idle_pct = 56;
            recv_idle_pct = 26;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        @(negedge i_clk);
    endtask

    task automatic random_word(output acceu_pkg::t_item w, output bit ua);
        int sel;
        int hi;
        int lo;
        w = '0;
        sel = $urandom_range(99);
        w.op = (sel < 93) ? 6'($urandom_range(46)) : 6'($urandom_range(63, 47));
        sel = $urandom_range(99);
        if (sel < 12) begin
            case ($urandom_range(5))
                0: w.operand = 8'h00;
                1: w.operand = 8'h01;
                2: w.operand = 8'h7F;
                3: w.operand = 8'h80;
                4: w.operand = 8'hFF;
                default: w.operand = 8'h99;
            endcase
        end else if (sel < 35 && fd) begin
            // packed decimal digits while decimal mode is on
            hi = $urandom_range(9);
            lo = $urandom_range(9);
            w.operand[7:4] = 4'(hi);
            w.operand[3:0] = 4'(lo);
        end else begin
            w.operand = 8'($urandom_range(255));
        end
        sel = $urandom_range(99);
        if (sel < 8) begin
            w.next_pc = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end else if (sel < 35) begin
            // close to a page edge so that branches cross pages both ways
            w.next_pc[15:8] = 8'($urandom_range(255));
            w.next_pc[7:0] = $urandom_range(1) ? 8'($urandom_range(255, 240))
                                               : 8'($urandom_range(15));
        end else begin
            w.next_pc = 16'($urandom_range(65535));
        end
        ua = 1'($urandom_range(1));
    endtask

    task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
        if (got !== want) begin
            err_count++;
            if (err_count <= 10)
                $display("mismatch in %s on result word %0d: expected %h, got %h",
                         name, results_seen, want, got);
        end
    endtask

    // output side: checks every word taken against the oldest prediction
    always @(posedge i_clk) begin : result_check
        acceu_pkg::t_result got;
        acceu_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_words.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("result word %0d arrived with nothing expected: %h",
                             results_seen, m_axis_tdata);
            end else begin
                want = expected_words.pop_front();
                check_field("mem_data", 16'(got.mem_data), 16'(want.mem_data));
                check_field("mem_write", 16'(got.mem_write), 16'(want.mem_write));
                check_field("acc_out", 16'(got.acc_out), 16'(want.acc_out));
                check_field("x_out", 16'(got.x_out), 16'(want.x_out));
                check_field("y_out", 16'(got.y_out), 16'(want.y_out));
                check_field("sp_out", 16'(got.sp_out), 16'(want.sp_out));
                check_field("status_out", 16'(got.status_out), 16'(want.status_out));
                check_field("new_pc", got.new_pc, want.new_pc);
                check_field("branch_taken", 16'(got.branch_taken), 16'(want.branch_taken));
                check_field("extra_cycles", 16'(got.extra_cycles), 16'(want.extra_cycles));
            end
            results_seen++;
        end
    end

    // receiver: random back-pressure plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_req && !hold_started) begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        m_axis_tready = (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        if (hold_left > 0) hold_left--;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && !s_axis_tready) input_stalls++;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= STALL_LIMIT) begin
            $display("no word moved for %0d cycles, %0d results outstanding",
                     idle_run, expected_words.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        t_stim_row          rows[$];
        acceu_pkg::t_item   w;
        bit                 ua;
        acceu_pkg::t_result none;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        hold_req = 1'b0;
        words_sent = 0;
        decimal_ops = 0;
        taken_branches = 0;
        rmw_ops = 0;
        send_idle_pct = 26;
        none = '0;
        acc_q = 8'h00;
        x_q = 8'h00;
        y_q = 8'h00;
        sp_q = 8'hFF;
        {fc, fz, fi, fd, fv, fn} = '0;

        rows.push_back(typed_row(acceu_pkg::OP_NOP, 8'h00, 1'b0, 16'h0000, 8'h00, 8'h20));
        rows.push_back(typed_row(acceu_pkg::OP_LDA, 8'hFF, 1'b0, 16'hFFFF, 8'hFF, 8'hA0));
        rows.push_back(typed_row(acceu_pkg::OP_ADC, 8'h01, 1'b0, 16'h1234, 8'h00, 8'h23));
        rows.push_back(typed_row(OP_UNDEF_TOP, 8'hFF, 1'b1, 16'h8000, 8'h00, 8'h23));
        rows.push_back(plain_row(acceu_pkg::OP_SBC, 8'h00, 1'b1, 16'h00FF));
        rows.push_back(plain_row(acceu_pkg::OP_SED, 8'h00, 1'b0, 16'h0100));
        rows.push_back(plain_row(acceu_pkg::OP_LDA, 8'h99, 1'b0, 16'h0102));
        rows.push_back(plain_row(acceu_pkg::OP_ADC, 8'h01, 1'b0, 16'h0104));
        rows.push_back(plain_row(acceu_pkg::OP_SBC, 8'h02, 1'b0, 16'h0106));
        rows.push_back(plain_row(acceu_pkg::OP_SBC, 8'hFF, 1'b0, 16'h0108));
        rows.push_back(plain_row(acceu_pkg::OP_CLD, 8'h00, 1'b0, 16'h010A));
        rows.push_back(plain_row(acceu_pkg::OP_BIT, 8'hC0, 1'b0, 16'h010C));
        rows.push_back(plain_row(acceu_pkg::OP_LDX, 8'h80, 1'b0, 16'h010E));
        rows.push_back(plain_row(acceu_pkg::OP_CPX, 8'h80, 1'b0, 16'h0110));
        rows.push_back(plain_row(acceu_pkg::OP_LDY, 8'h7F, 1'b0, 16'h0112));
        rows.push_back(plain_row(acceu_pkg::OP_CPY, 8'hFF, 1'b0, 16'h0114));
        rows.push_back(plain_row(acceu_pkg::OP_STA, 8'h55, 1'b0, 16'h0116));
        rows.push_back(plain_row(acceu_pkg::OP_INC, 8'hFF, 1'b0, 16'h0118));
        rows.push_back(plain_row(acceu_pkg::OP_DEC, 8'h00, 1'b0, 16'h011A));
        rows.push_back(plain_row(acceu_pkg::OP_ASL, 8'h00, 1'b1, 16'h011C));
        rows.push_back(plain_row(acceu_pkg::OP_ROR, 8'h01, 1'b0, 16'h011E));
        rows.push_back(plain_row(acceu_pkg::OP_TSX, 8'h00, 1'b0, 16'h0120));
        rows.push_back(plain_row(acceu_pkg::OP_DEX, 8'h00, 1'b0, 16'h0122));
        rows.push_back(plain_row(acceu_pkg::OP_TXS, 8'h00, 1'b0, 16'h0124));
        rows.push_back(plain_row(acceu_pkg::OP_SEC, 8'h00, 1'b0, 16'h0126));
        // taken backward branch that wraps below address zero
        rows.push_back(plain_row(acceu_pkg::OP_BCS, 8'h80, 1'b0, 16'h0000));
        rows.push_back(plain_row(acceu_pkg::OP_BNE, 8'h7F, 1'b0, 16'h00FF));
        rows.push_back(plain_row(acceu_pkg::OP_CLV, 8'h00, 1'b0, 16'h0200));
        rows.push_back(plain_row(acceu_pkg::OP_SEI, 8'h00, 1'b0, 16'h0202));

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (rows[k]) send_word(rows[k].word, rows[k].on_acc, rows[k].typed, rows[k].want);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == PAUSE_AT) begin
                // let the pipe drain completely before going on
                s_axis_tvalid = 1'b0;
                do @(negedge i_clk); while (expected_words.size() != 0);
            end
            random_word(w, ua);
            send_word(w, ua, 1'b0, none);
        end
        s_axis_tvalid = 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("sent %0d words, checked %0d results; %0d decimal add/sub, %0d taken branches,",
                 words_sent, results_seen, decimal_ops, taken_branches);
        $display("%0d memory read-modify-writes, %0d cycles of input back-pressure, %0d mismatches",
                 rmw_ops, input_stalls, err_count);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
